// File: rtl/mss_pkg.sv
`default_nettype none

package mss_pkg;

    localparam int STORE_DEPTH_DEF = 16;
    localparam int STACK_COUNT_DEF = 4;

    localparam int SEL_W  = 2;
    localparam int DATA_W = 32;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_COMMIT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic refused;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/mss_ctrl.sv
`default_nettype none

module mss_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mss_pkg::dp_cmd_t       cmd,
    input  wire mss_pkg::dp_stat_t stat
);

    mss_pkg::state_t state_reg;
    mss_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mss_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = mss_pkg::S_LOOKUP;
            end
            mss_pkg::S_LOOKUP:
            begin
                if (stat.refused)
                    state_next = mss_pkg::S_RESP;
                else
                    state_next = mss_pkg::S_COMMIT;
            end
            mss_pkg::S_COMMIT:
            begin
                state_next = mss_pkg::S_RESP;
            end
            mss_pkg::S_RESP:
            begin
                if (out_free)
                    state_next = mss_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mss_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            mss_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            mss_pkg::S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            mss_pkg::S_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            mss_pkg::S_RESP:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // result register: set on load, dropped once taken
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mss_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/mss_datapath.sv
`default_nettype none

module mss_datapath #(
    parameter int STORE_DEPTH = mss_pkg::STORE_DEPTH_DEF,
    parameter int STACK_COUNT = mss_pkg::STACK_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mss_pkg::dp_cmd_t              cmd,
    output mss_pkg::dp_stat_t                  stat,
    input  wire logic                          req_type,
    input  wire logic [mss_pkg::SEL_W-1:0]     stack_sel,
    input  wire logic signed [mss_pkg::DATA_W-1:0] push_value,
    output logic signed [mss_pkg::DATA_W-1:0]  pop_value,
    output mss_pkg::status_t                   status,
    output logic                               store_full,
    output logic                               stack_empty
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int HEAD_W = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
    localparam int EXT_W  = (HEAD_W > mss_pkg::SEL_W) ? HEAD_W : mss_pkg::SEL_W;

    // link entry: valid bit on top of the slot index
    typedef logic [ADDR_W:0] link_t;

    logic [mss_pkg::DATA_W-1:0] data_mem [STORE_DEPTH];
    link_t                      link_mem [STORE_DEPTH];
    logic [ADDR_W-1:0]          head_mem [STACK_COUNT];

    logic [STACK_COUNT-1:0]     head_valid_reg;
    logic [ADDR_W-1:0]          free_idx_reg;
    logic                       free_valid_reg;
    logic [CNT_W-1:0]           fill_reg;

    logic                       req_type_reg;
    logic [HEAD_W-1:0]          sel_idx_reg;
    logic                       sel_ok_reg;
    logic [mss_pkg::DATA_W-1:0] value_reg;

    logic [ADDR_W-1:0]          head_rd_reg;
    logic [ADDR_W-1:0]          slot_reg;
    link_t                      link_rd_reg;
    logic [mss_pkg::DATA_W-1:0] data_rd_reg;
    logic                       top_valid_reg;
    logic                       fresh_reg;

    logic [mss_pkg::DATA_W-1:0] res_pop_reg;
    mss_pkg::status_t           res_status_reg;
    logic                       res_full_reg;
    logic                       res_empty_reg;

    logic [EXT_W-1:0]           sel_ext;
    logic [HEAD_W-1:0]          sel_idx_in;
    logic                       sel_ok_in;
    logic                       is_push;
    logic                       top_valid;
    logic [ADDR_W-1:0]          slot;
    logic                       refused;
    logic [CNT_W-1:0]           slot_plus;
    logic                       next_valid;
    logic [ADDR_W-1:0]          next_idx;

    assign sel_ext    = EXT_W'(stack_sel);
    assign sel_idx_in = sel_ext[HEAD_W-1:0];
    assign sel_ok_in  = 32'(stack_sel) < 32'(STACK_COUNT);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            sel_idx_reg  <= sel_idx_in;
            sel_ok_reg   <= sel_ok_in;
            value_reg    <= push_value;
        end
    end

    // lookup: pick the slot and decide whether the request is refused
    assign is_push   = (req_type_reg == mss_pkg::REQ_PUSH);
    assign top_valid = sel_ok_reg && head_valid_reg[sel_idx_reg];
    assign slot      = is_push ? free_idx_reg : head_rd_reg;
    assign refused   = is_push ? (!sel_ok_reg || !free_valid_reg)
                               : (!sel_ok_reg || !top_valid);
    assign stat.refused = refused;

    // slots at or above the fill mark were never linked: the next slot follows in index order
    assign slot_plus  = CNT_W'(slot_reg) + CNT_W'(1);
    assign next_valid = fresh_reg ? (32'(slot_plus) < 32'(STORE_DEPTH)) : link_rd_reg[ADDR_W];
    assign next_idx   = fresh_reg ? slot_plus[ADDR_W-1:0] : link_rd_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            head_rd_reg <= head_mem[sel_idx_in];
        if (cmd.commit && sel_ok_reg)
        begin
            if (is_push)
                head_mem[sel_idx_reg] <= slot_reg;
            else
                head_mem[sel_idx_reg] <= next_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            link_rd_reg <= link_mem[slot];
            data_rd_reg <= data_mem[slot];
        end
        if (cmd.commit)
        begin
            if (is_push)
            begin
                link_mem[slot_reg] <= {top_valid_reg, head_rd_reg};
                data_mem[slot_reg] <= value_reg;
            end
            else
                link_mem[slot_reg] <= {free_valid_reg, free_idx_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            slot_reg      <= slot;
            top_valid_reg <= top_valid;
            fresh_reg     <= CNT_W'(slot) >= fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            free_idx_reg   <= '0;
            free_valid_reg <= 1'b1;
            fill_reg       <= '0;
        end
        else if (cmd.commit)
        begin
            if (is_push)
            begin
                free_idx_reg   <= next_idx;
                free_valid_reg <= next_valid;
                head_valid_reg[sel_idx_reg] <= 1'b1;
                if (fresh_reg)
                    fill_reg <= fill_reg + CNT_W'(1);
            end
            else
            begin
                free_idx_reg   <= slot_reg;
                free_valid_reg <= 1'b1;
                head_valid_reg[sel_idx_reg] <= next_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup && refused)
        begin
            res_pop_reg    <= '0;
            res_status_reg <= is_push ? mss_pkg::STATUS_FULL : mss_pkg::STATUS_EMPTY;
            res_full_reg   <= !free_valid_reg;
            res_empty_reg  <= !top_valid;
        end
        else if (cmd.commit)
        begin
            res_status_reg <= mss_pkg::STATUS_DONE;
            if (is_push)
            begin
                res_pop_reg   <= '0;
                res_full_reg  <= !next_valid;
                res_empty_reg <= 1'b0;
            end
            else
            begin
                res_pop_reg   <= data_rd_reg;
                res_full_reg  <= 1'b0;
                res_empty_reg <= !next_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pop_value   <= res_pop_reg;
            status      <= res_status_reg;
            store_full  <= res_full_reg;
            stack_empty <= res_empty_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/multi_stack_shared_store_top.sv
// channel | direction | handshake          | fields
// --------+-----------+--------------------+------------------------------------------
// request | in        | in_valid/in_ready  | req_type, stack_sel, push_value
// result  | out       | out_valid/out_ready| pop_value, status, store_full, stack_empty
//
// one request at a time: each goes through the accept / lookup / commit / respond
// sequence around the link store read; a refused request skips the commit step
// reset: stacks empty, free list in slot order; no clearing pass (fill mark tracks
// slots not yet linked)
// a result held by out_ready low stalls the block in its respond step
`default_nettype none

module multi_stack_shared_store_top #(
    parameter int STORE_DEPTH = mss_pkg::STORE_DEPTH_DEF,
    parameter int STACK_COUNT = mss_pkg::STACK_COUNT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              req_type,
    input  wire logic [mss_pkg::SEL_W-1:0]         stack_sel,
    input  wire logic signed [mss_pkg::DATA_W-1:0] push_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [mss_pkg::DATA_W-1:0]      pop_value,
    output mss_pkg::status_t                       status,
    output logic                                   store_full,
    output logic                                   stack_empty
);

    mss_pkg::dp_cmd_t  cmd;
    mss_pkg::dp_stat_t stat;

    mss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mss_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .STACK_COUNT (STACK_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .stack_sel   (stack_sel),
        .push_value  (push_value),
        .pop_value   (pop_value),
        .status      (status),
        .store_full  (store_full),
        .stack_empty (stack_empty)
    );

endmodule

`default_nettype wire

// File: rtl/mss_checker.sv
`default_nettype none

module mss_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic signed [mss_pkg::DATA_W-1:0] pop_value,
    input wire mss_pkg::status_t                  status,
    input wire logic                              stack_empty
);

    // one request in flight: no second transfer right after one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while another is in flight");

    // refused requests return no value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == mss_pkg::STATUS_FULL || status == mss_pkg::STATUS_EMPTY))
        |-> (pop_value == '0))
        else $error("refused request returned a value");

    // a refused pop means the stack was, and still is, empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == mss_pkg::STATUS_EMPTY) |-> stack_empty)
        else $error("empty refusal on a non-empty stack");

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pop_value) && $stable(status)))
        else $error("stalled result changed");

endmodule

bind multi_stack_shared_store_top mss_checker u_mss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pop_value   (pop_value),
    .status      (status),
    .stack_empty (stack_empty)
);

`default_nettype wire

// File: test/tb_multi_stack_shared_store_top.sv
module tb_multi_stack_shared_store_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH            = mss_pkg::STORE_DEPTH_DEF;
    localparam int COUNT            = mss_pkg::STACK_COUNT_DEF;
    localparam int DATA_W           = mss_pkg::DATA_W;
    localparam int SEL_W            = mss_pkg::SEL_W;
    localparam int ADDR_W           = $clog2(DEPTH);
    localparam int IDX_W            = ADDR_W + 1;
    localparam int RANDOM_PER_PHASE = 542;
    localparam int DRAIN_CYCLES     = 12;
    localparam int QUIET_LIMIT      = 5000;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } slot_ref_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        mss_pkg::status_t         status;
        logic                     full;
        logic                     empty;
    } stack_result_t;

    class stack_scoreboard;
        logic [DATA_W-1:0] slot_data [DEPTH];
        slot_ref_t         slot_link [DEPTH];
        slot_ref_t         top_of [COUNT];
        slot_ref_t         free_top;
        stack_result_t     expected_results [$];
        int                mismatches;
        int                checked;
        int                pushes_stored;
        int                pops_returned;
        int                full_refusals;
        int                empty_refusals;

        function new();
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_data[i]     = '0;
                slot_link[i].idx = IDX_W'(i + 1);
                slot_link[i].ok  = (i + 1 < DEPTH);
            end
            for (int i = 0; i < COUNT; i++)
                top_of[i] = '0;
            free_top = '{ok: 1'b1, idx: '0};
        endfunction

        function bit usable(slot_ref_t p);
            return p.ok && (int'(p.idx) < DEPTH);
        endfunction

        function void note_request(logic kind, logic [SEL_W-1:0] sel,
                                   logic [DATA_W-1:0] val);
            stack_result_t     r;
            logic [ADDR_W-1:0] s;
            bit                sel_ok;
            sel_ok      = (int'(sel) < COUNT);
            r.pop_value = '0;
            r.status    = mss_pkg::STATUS_DONE;
            if (kind == mss_pkg::REQ_PUSH)
            begin
                if (!sel_ok || !usable(free_top))
                begin
                    r.status = mss_pkg::STATUS_FULL;
                    full_refusals++;
                end
                else
                begin
                    s            = free_top.idx[ADDR_W-1:0];
                    free_top     = slot_link[s];
                    slot_data[s] = val;
                    slot_link[s] = top_of[sel];
                    top_of[sel]  = '{ok: 1'b1, idx: IDX_W'(s)};
                    pushes_stored++;
                end
            end
            else
            begin
                if (!sel_ok || !usable(top_of[sel]))
                begin
                    r.status = mss_pkg::STATUS_EMPTY;
                    empty_refusals++;
                end
                else
                begin
                    s            = top_of[sel].idx[ADDR_W-1:0];
                    top_of[sel]  = slot_link[s];
                    slot_link[s] = free_top;
                    free_top     = '{ok: 1'b1, idx: IDX_W'(s)};
                    r.pop_value  = slot_data[s];
                    pops_returned++;
                end
            end
            r.full  = !usable(free_top);
            r.empty = sel_ok ? !usable(top_of[sel]) : 1'b1;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            mismatches++;
            $display("[%0t] result %0d: %s got %h expected %h",
                     $realtime, checked, what, got, want);
        endtask

        task check_result(logic signed [DATA_W-1:0] pv, mss_pkg::status_t st, logic full,
                          logic empty);
            stack_result_t want;
            checked++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("transfer with nothing pending", pv, '0);
                return;
            end
            want = expected_results.pop_front();
            if (pv !== want.pop_value)
                report_mismatch("pop_value", pv, want.pop_value);
            if (st !== want.status)
                report_mismatch("status", DATA_W'(st), DATA_W'(want.status));
            if (full !== want.full)
                report_mismatch("store_full", DATA_W'(full), DATA_W'(want.full));
            if (empty !== want.empty)
                report_mismatch("stack_empty", DATA_W'(empty), DATA_W'(want.empty));
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     req_type = mss_pkg::REQ_PUSH;
    logic [SEL_W-1:0]         stack_sel = '0;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] pop_value;
    mss_pkg::status_t         status;
    logic                     store_full;
    logic                     stack_empty;

    int              send_gap_pct = 0;
    int              recv_gap_pct = 0;
    int              quiet_cycles = 0;
    stack_scoreboard board = new();

    multi_stack_shared_store_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .stack_sel  (stack_sel),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status),
        .store_full (store_full),
        .stack_empty(stack_empty)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic send_request(logic kind, logic [SEL_W-1:0] sel, logic [DATA_W-1:0] val);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        stack_sel  <= sel;
        push_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(kind, sel, val);
    endtask

    // result side: check on transfer, then pick the next ready level
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_result(pop_value, status, store_full, stack_empty);
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic [DATA_W-1:0] val;
        logic              kind;
        logic [SEL_W-1:0]  sel;
        int                push_bias;
        int                run_left;
        int                focus;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_gap_pct = 21;
        recv_gap_pct = 49;

        // every stack starts empty
        for (int s = 0; s < COUNT; s++)
            send_request(mss_pkg::REQ_POP, SEL_W'(s), $urandom);
        // fill the whole store across all stacks, extremes first
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i)
                0:       val = 32'h8000_0000;
                1:       val = 32'h7fff_ffff;
                2:       val = 32'hffff_ffff;
                3:       val = 32'h0000_0000;
                default: val = $urandom;
            endcase
            send_request(mss_pkg::REQ_PUSH, SEL_W'(i % COUNT), val);
        end
        send_request(mss_pkg::REQ_PUSH, SEL_W'(1), 32'h1234_5678);
        send_request(mss_pkg::REQ_POP, SEL_W'(3), $urandom);
        send_request(mss_pkg::REQ_POP, SEL_W'(3), $urandom);
        send_request(mss_pkg::REQ_POP, SEL_W'(0), $urandom);

        run_left  = 0;
        push_bias = 50;
        focus     = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct = 21;
                    recv_gap_pct = 49;
                end
                1:
                begin
                    send_gap_pct = 49;
                    recv_gap_pct = 21;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // runs biased toward filling, draining or churning the store
                if (run_left == 0)
                begin
                    case ($urandom_range(2))
                        0:       push_bias = 15;
                        1:       push_bias = 50;
                        default: push_bias = 85;
                    endcase
                    run_left = $urandom_range(8, 60);
                    focus    = $urandom_range(COUNT - 1);
                end
                run_left--;
                kind = ($urandom_range(99) < push_bias) ? mss_pkg::REQ_PUSH : mss_pkg::REQ_POP;
                sel  = ($urandom_range(99) < 60) ? SEL_W'(focus)
                                                 : SEL_W'($urandom_range(COUNT - 1));
                case ($urandom_range(9))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7fff_ffff;
                    2:       val = 32'hffff_ffff;
                    3:       val = 32'h0000_0000;
                    default: val = $urandom;
                endcase
                send_request(kind, sel, val);
            end
        end
        in_valid <= 1'b0;

        while (board.expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests under three idle patterns: %0d pushes stored, %0d popped",
                 board.checked, board.pushes_stored, board.pops_returned);
        $display("refused %0d pushes on a full store, %0d pops on an empty stack, %0d mismatches",
                 board.full_refusals, board.empty_refusals, board.mismatches);
        if (board.mismatches == 0 && board.expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: sim.f
rtl/mss_pkg.sv
rtl/mss_ctrl.sv
rtl/mss_datapath.sv
rtl/multi_stack_shared_store_top.sv
rtl/mss_checker.sv
test/tb_multi_stack_shared_store_top.sv
